>>> rtl/tcw_pkg.sv
`timescale 1ns / 1ps
package tcw_pkg;

   localparam int COLS_DEF     = 80;
   localparam int ROWS_DEF     = 25;

   localparam int CHAR_W       = 8;
   localparam int ATTR_W       = 8;
   localparam int CELL_W       = CHAR_W + ATTR_W;
   localparam int COL_IN_W     = 7;
   localparam int ROW_IN_W     = 5;
   localparam int CURSOR_W     = 11;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef enum logic {
      SW_IDLE,
      SW_CLEAR
   } sweep_state_type;

endpackage

>>> rtl/tcw_req_if.sv
`timescale 1ns / 1ps
interface tcw_req_if;
   import tcw_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [CHAR_W-1:0]   char_code;
   logic [ATTR_W-1:0]   attr;
   logic                use_position;
   logic [COL_IN_W-1:0] col_in;
   logic [ROW_IN_W-1:0] row_in;

   modport source (
      output valid, req_type, char_code, attr, use_position, col_in, row_in,
      input  ready
   );

   modport sink (
      input  valid, req_type, char_code, attr, use_position, col_in, row_in,
      output ready
   );

endinterface

>>> rtl/tcw_rsp_if.sv
`timescale 1ns / 1ps
interface tcw_rsp_if;
   import tcw_pkg::*;

   logic                valid;
   logic                ready;
   logic [CURSOR_W-1:0] cursor_cell;
   logic [CHAR_W-1:0]   read_char;
   logic [ATTR_W-1:0]   read_attr;
   logic                scrolled;

   modport source (
      output valid, cursor_cell, read_char, read_attr, scrolled,
      input  ready
   );

   modport sink (
      input  valid, cursor_cell, read_char, read_attr, scrolled,
      output ready
   );

endinterface

>>> rtl/tcw_ram.sv
`timescale 1ns / 1ps
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data_ff
);

   logic [WIDTH-1:0] cells_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

endmodule

>>> rtl/text_console_cell_writer_core.sv
`timescale 1ns / 1ps
// A taken request is registered in the input stage and then in the result stage before its response beat is valid.
// Throughput: one request per cycle unless the response is stalled or a row clear is running;
// a put that scrolls holds off requests while the retired top row is zeroed, one cell per cycle (one RAM write port).
// Reset: synchronous; the whole cell store is then zeroed with
// req_bus.ready low, and cursor and top row start at zero.
module text_console_cell_writer_core #(
   parameter int COLS = tcw_pkg::COLS_DEF,
   parameter int ROWS = tcw_pkg::ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tcw_req_if.sink     req_bus,
   tcw_rsp_if.source   rsp_bus
);
   import tcw_pkg::*;

   localparam int CELLS     = COLS * ROWS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int COL_W     = $clog2(COLS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int COL_CMP_W = (COL_W > COL_IN_W ? COL_W : COL_IN_W) + 1;
   localparam int ROW_CMP_W = (ROW_W > ROW_IN_W ? ROW_W : ROW_IN_W) + 1;

   // input stage
   logic                a_valid_ff;
   logic                a_req_type_ff;
   logic [CHAR_W-1:0]   a_char_ff;
   logic [ATTR_W-1:0]   a_attr_ff;
   logic                a_use_pos_ff;
   logic [COL_IN_W-1:0] a_col_ff;
   logic [ROW_IN_W-1:0] a_row_ff;

   // console state
   logic [COL_W-1:0]    cur_col_ff;
   logic [ROW_W-1:0]    cur_row_ff;
   logic [ROW_W-1:0]    top_row_ff;

   // result stage
   logic                b_valid_ff;
   logic                b_is_read_ff;
   logic [CURSOR_W-1:0] b_cursor_ff;
   logic                b_scrolled_ff;

   // clearing sweep
   sweep_state_type     sw_state_ff, sw_state_in;
   logic [ADDR_W-1:0]   sw_addr_ff, sw_addr_in;
   logic [ADDR_W-1:0]   sw_cnt_ff, sw_cnt_in;
   logic                sw_busy;

   logic                a_go;
   logic                is_read;
   logic                is_newline;
   logic [COL_CMP_W-1:0] col_ext;
   logic [ROW_CMP_W-1:0] row_ext;
   logic [COL_W-1:0]    col_clamp;
   logic [ROW_W-1:0]    row_clamp;
   logic [COL_W-1:0]    put_col;
   logic [ROW_W-1:0]    put_row;
   logic                last_col;
   logic                last_row;
   logic                wrap;
   logic                put_scroll;
   logic [COL_W-1:0]    next_col;
   logic [ROW_W-1:0]    next_row;
   logic [COL_W-1:0]    addr_col;
   logic [ROW_W-1:0]    addr_row;
   logic [ROW_W:0]      prow_sum;
   logic [ROW_W-1:0]    prow;
   logic [ADDR_W-1:0]   cell_addr;
   logic [COL_W-1:0]    out_col;
   logic [ROW_W-1:0]    out_row;
   logic [ADDR_W-1:0]   out_lin;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [CELL_W-1:0]   ram_wdata;
   logic                ram_re;
   logic [CELL_W-1:0]   ram_rdata;

   assign a_go          = a_valid_ff && !sw_busy && (!b_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !sw_busy && (!a_valid_ff || a_go);

   always_comb begin
      is_read    = (a_req_type_ff == REQ_READ);
      is_newline = (a_char_ff == NEWLINE_CODE);

      col_ext   = COL_CMP_W'(a_col_ff);
      row_ext   = ROW_CMP_W'(a_row_ff);
      col_clamp = (col_ext >= COL_CMP_W'(COLS)) ? COL_W'(COLS - 1) : col_ext[COL_W-1:0];
      row_clamp = (row_ext >= ROW_CMP_W'(ROWS)) ? ROW_W'(ROWS - 1) : row_ext[ROW_W-1:0];

      put_col = a_use_pos_ff ? col_clamp : cur_col_ff;
      put_row = a_use_pos_ff ? row_clamp : cur_row_ff;

      last_col   = (put_col == COL_W'(COLS - 1));
      last_row   = (put_row == ROW_W'(ROWS - 1));
      wrap       = is_newline || last_col;
      put_scroll = !is_read && wrap && last_row;

      next_col = wrap ? '0 : COL_W'(put_col + 1'b1);
      if (wrap && !last_row) begin
         next_row = ROW_W'(put_row + 1'b1);
      end else begin
         next_row = put_row;
      end

      addr_col = is_read ? col_clamp : put_col;
      addr_row = is_read ? row_clamp : put_row;
      prow_sum = {1'b0, top_row_ff} + {1'b0, addr_row};
      if (prow_sum >= (ROW_W + 1)'(ROWS)) begin
         prow = ROW_W'(prow_sum - (ROW_W + 1)'(ROWS));
      end else begin
         prow = prow_sum[ROW_W-1:0];
      end
      cell_addr = ADDR_W'(ADDR_W'(prow) * ADDR_W'(COLS)) + ADDR_W'(addr_col);

      out_col = is_read ? cur_col_ff : next_col;
      out_row = is_read ? cur_row_ff : next_row;
      out_lin = ADDR_W'(ADDR_W'(out_row) * ADDR_W'(COLS)) + ADDR_W'(out_col);
   end

   // sweep next state
   always_comb begin
      sw_state_in = sw_state_ff;
      sw_addr_in  = sw_addr_ff;
      sw_cnt_in   = sw_cnt_ff;
      case (sw_state_ff)
         SW_IDLE: begin
            if (a_go && put_scroll) begin
               sw_state_in = SW_CLEAR;
               sw_addr_in  = ADDR_W'(ADDR_W'(top_row_ff) * ADDR_W'(COLS));
               sw_cnt_in   = ADDR_W'(COLS - 1);
            end
         end
         SW_CLEAR: begin
            sw_addr_in = sw_addr_ff + 1'b1;
            sw_cnt_in  = sw_cnt_ff - 1'b1;
            if (sw_cnt_ff == '0) begin
               sw_state_in = SW_IDLE;
            end
         end
         default: begin
            sw_state_in = SW_IDLE;
         end
      endcase
   end

   // sweep outputs
   always_comb begin
      case (sw_state_ff)
         SW_CLEAR: sw_busy = 1'b1;
         default:  sw_busy = 1'b0;
      endcase
   end

   always_comb begin
      if (sw_busy) begin
         ram_we    = 1'b1;
         ram_waddr = sw_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = a_go && !is_read && !is_newline;
         ram_waddr = cell_addr;
         ram_wdata = {a_attr_ff, a_char_ff};
      end
      ram_re = a_go && is_read;
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_en      (ram_re),
      .rd_addr    (cell_addr),
      .rd_data_ff (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_state_ff <= SW_CLEAR;
         sw_addr_ff  <= '0;
         sw_cnt_ff   <= ADDR_W'(CELLS - 1);
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         cur_col_ff  <= '0;
         cur_row_ff  <= '0;
         top_row_ff  <= '0;
      end else begin
         sw_state_ff <= sw_state_in;
         sw_addr_ff  <= sw_addr_in;
         sw_cnt_ff   <= sw_cnt_in;

         if (req_bus.valid && req_bus.ready) begin
            a_valid_ff <= 1'b1;
         end else if (a_go) begin
            a_valid_ff <= 1'b0;
         end

         if (a_go) begin
            b_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            b_valid_ff <= 1'b0;
         end

         if (a_go && !is_read) begin
            cur_col_ff <= next_col;
            cur_row_ff <= next_row;
            if (put_scroll) begin
               top_row_ff <= (top_row_ff == ROW_W'(ROWS - 1)) ? '0
                                                              : ROW_W'(top_row_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         a_req_type_ff <= req_bus.req_type;
         a_char_ff     <= req_bus.char_code;
         a_attr_ff     <= req_bus.attr;
         a_use_pos_ff  <= req_bus.use_position;
         a_col_ff      <= req_bus.col_in;
         a_row_ff      <= req_bus.row_in;
      end
      if (a_go) begin
         b_is_read_ff  <= is_read;
         b_cursor_ff   <= CURSOR_W'(out_lin);
         b_scrolled_ff <= put_scroll;
      end
   end

   assign rsp_bus.valid       = b_valid_ff;
   assign rsp_bus.cursor_cell = b_cursor_ff;
   assign rsp_bus.scrolled    = b_scrolled_ff;
   assign rsp_bus.read_char   = b_is_read_ff ? ram_rdata[CHAR_W-1:0] : '0;
   assign rsp_bus.read_attr   = b_is_read_ff ? ram_rdata[CELL_W-1:CHAR_W] : '0;

   a_scroll_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (a_go && put_scroll) |=>
         (sw_state_ff == SW_CLEAR && sw_cnt_ff == ADDR_W'(COLS - 1)))
      else $error("scroll did not start a row clear");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (int'(cur_col_ff) < COLS) && (int'(cur_row_ff) < ROWS) && (int'(top_row_ff) < ROWS))
      else $error("cursor or top row out of range");

   a_held_read_stable: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_is_read_ff && !rsp_bus.ready) |=> $stable(ram_rdata))
      else $error("read data changed under a stalled beat");

   a_scroll_lands_last_row: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_scrolled_ff) |->
         (b_cursor_ff == CURSOR_W'((ROWS - 1) * COLS)))
      else $error("scroll left cursor off the start of the last row");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
   import tcw_pkg::*;

   localparam int COLS         = COLS_DEF;
   localparam int ROWS         = ROWS_DEF;
   localparam int CELLS        = COLS * ROWS;
   localparam int IDLE_LIMIT   = 10000;
   localparam int RANDOM_ITEMS = 500;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic                req_type;
      logic [CHAR_W-1:0]   char_code;
      logic [ATTR_W-1:0]   attr;
      logic                use_position;
      logic [COL_IN_W-1:0] col_in;
      logic [ROW_IN_W-1:0] row_in;
      bit                  hold_for_drain;
   } console_req_type;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_cell;
      logic [CHAR_W-1:0]   read_char;
      logic [ATTR_W-1:0]   read_attr;
      logic                scrolled;
   } console_rsp_type;

   logic clock = 1'b0;
   logic reset;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   text_console_cell_writer_core #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   console_req_type pending_reqs[$];
   console_rsp_type expected_rsps[$];

   logic [CELL_W-1:0] screen_cells [CELLS];
   int unsigned       screen_cursor;
   int unsigned       screen_top;

   int unsigned issued_count  = 0;
   int unsigned retired_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned put_count = 0;
   int unsigned read_count = 0;
   int unsigned scroll_count = 0;
   int unsigned drain_count = 0;
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;
   int unsigned idle_cycles = 0;
   logic [7:0]  stall_mask = 8'hFF;
   int unsigned stall_phase = 0;

   function automatic console_rsp_type console_apply(console_req_type r);
      int unsigned col;
      int unsigned row;
      int unsigned pos;
      int unsigned base;
      logic [CELL_W-1:0] stored;
      console_rsp_type o;
      col = (r.col_in >= COLS) ? COLS - 1 : r.col_in;
      row = (r.row_in >= ROWS) ? ROWS - 1 : r.row_in;
      o = '0;
      if (r.req_type == REQ_READ) begin
         read_count++;
         stored = screen_cells[((screen_top + row) % ROWS) * COLS + col];
         o.read_char = stored[CHAR_W-1:0];
         o.read_attr = stored[CELL_W-1:CHAR_W];
      end else begin
         put_count++;
         if (r.use_position)
            screen_cursor = row * COLS + col;
         if (screen_cursor >= CELLS)
            screen_cursor = CELLS - 1;
         pos = screen_cursor;
         if (r.char_code == NEWLINE_CODE)
            pos = (pos / COLS) * COLS + COLS - 1;
         else
            screen_cells[((screen_top + pos / COLS) % ROWS) * COLS + pos % COLS] =
               {r.attr, r.char_code};
         pos++;
         if (pos >= CELLS) begin
            base = screen_top * COLS;
            for (int i = 0; i < COLS; i++)
               screen_cells[base + i] = '0;
            screen_top = (screen_top + 1) % ROWS;
            pos -= COLS;
            o.scrolled = 1'b1;
            scroll_count++;
         end
         screen_cursor = pos;
      end
      o.cursor_cell = screen_cursor[CURSOR_W-1:0];
      return o;
   endfunction

   task automatic add_req(input logic kind, input int unsigned ch, input int unsigned at,
                          input logic pos_en, input int unsigned col, input int unsigned row,
                          input bit drain);
      console_req_type r;
      r.req_type       = kind;
      r.char_code      = ch[CHAR_W-1:0];
      r.attr           = at[ATTR_W-1:0];
      r.use_position   = pos_en;
      r.col_in         = col[COL_IN_W-1:0];
      r.row_in         = row[ROW_IN_W-1:0];
      r.hold_for_drain = drain;
      pending_reqs.push_back(r);
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0t: beat %0d %s mismatch: expected %0d, got %0d",
                     $realtime, retired_count, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : req_driver
      bit          took;
      bit          present;
      int unsigned outstanding;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         took = req_bus.valid && req_bus.ready;
         if (took) begin
            expected_rsps.push_back(console_apply(pending_reqs.pop_front()));
            issued_count <= issued_count + 1;
            if (burst_left > 0)
               burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         if (!(req_bus.valid && !took)) begin
            outstanding = issued_count + took - retired_count;
            present = 1'b0;
            if (gap_left > 0)
               gap_left--;
            else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].hold_for_drain && outstanding != 0))
               present = 1'b1;
            req_bus.valid <= present;
            if (present) begin
               if (pending_reqs[0].hold_for_drain)
                  drain_count++;
               req_bus.req_type     <= pending_reqs[0].req_type;
               req_bus.char_code    <= pending_reqs[0].char_code;
               req_bus.attr         <= pending_reqs[0].attr;
               req_bus.use_position <= pending_reqs[0].use_position;
               req_bus.col_in       <= pending_reqs[0].col_in;
               req_bus.row_in       <= pending_reqs[0].row_in;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      console_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (retired_count >= issued_count) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: unexpected response beat, cursor_cell %0d",
                           $realtime, rsp_bus.cursor_cell);
            end else begin
               want = expected_rsps.pop_front();
               check_field("cursor_cell", want.cursor_cell, rsp_bus.cursor_cell);
               check_field("read_char", want.read_char, rsp_bus.read_char);
               check_field("read_attr", want.read_attr, rsp_bus.read_attr);
               check_field("scrolled", want.scrolled, rsp_bus.scrolled);
               retired_count <= retired_count + 1;
            end
         end
         stall_phase++;
         if (stall_phase % 50 == 0)
            stall_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
         else
            stall_mask = {stall_mask[6:0], stall_mask[7]};
         rsp_bus.ready <= stall_mask[0];
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, issued_count - retired_count);
            $display("tb failed");
            $finish;
         end
      end
   end

   initial begin
      int unsigned n;
      int unsigned len;
      int unsigned mode;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = REQ_PUT;
      req_bus.char_code    = '0;
      req_bus.attr         = '0;
      req_bus.use_position = 1'b0;
      req_bus.col_in       = '0;
      req_bus.row_in       = '0;
      rsp_bus.ready        = 1'b0;
      for (int i = 0; i < CELLS; i++)
         screen_cells[i] = '0;
      screen_cursor = 0;
      screen_top    = 0;

      add_req(REQ_READ, 0, 0, 1'b0, 0, 0, 1'b0);
      add_req(REQ_READ, NEWLINE_CODE, 8'hFF, 1'b1, 127, 31, 1'b0);
      add_req(REQ_PUT, 8'h41, 8'h0F, 1'b1, 0, 0, 1'b0);
      add_req(REQ_PUT, 8'h00, 8'h00, 1'b0, 127, 31, 1'b0);
      add_req(REQ_PUT, 8'hFF, 8'hFF, 1'b0, 0, 0, 1'b0);
      add_req(REQ_READ, 0, 0, 1'b0, 0, 0, 1'b1);
      add_req(REQ_READ, 0, 0, 1'b0, 1, 0, 1'b0);
      add_req(REQ_READ, 0, 0, 1'b0, 2, 0, 1'b0);
      add_req(REQ_PUT, NEWLINE_CODE, 8'h0E, 1'b0, 0, 0, 1'b0);
      add_req(REQ_PUT, 8'h0E, 8'h0E, 1'b1, 79, 0, 1'b0);
      add_req(REQ_PUT, NEWLINE_CODE, 8'h0F, 1'b1, 40, 12, 1'b0);
      add_req(REQ_PUT, 8'h55, 8'hAA, 1'b1, 127, 31, 1'b0);
      add_req(REQ_READ, 0, 0, 1'b0, 79, 23, 1'b0);
      add_req(REQ_READ, 0, 0, 1'b0, 0, 0, 1'b0);
      add_req(REQ_READ, 0, 0, 1'b0, 79, 24, 1'b0);
      add_req(REQ_PUT, NEWLINE_CODE, 8'h00, 1'b0, 0, 0, 1'b0);
      add_req(REQ_PUT, NEWLINE_CODE, 8'h00, 1'b1, 0, 24, 1'b0);
      add_req(REQ_PUT, 8'h7F, 8'h80, 1'b1, 100, 10, 1'b0);
      add_req(REQ_READ, 0, 0, 1'b0, 79, 10, 1'b0);
      add_req(REQ_PUT, 8'h2A, 8'h5C, 1'b1, 78, 24, 1'b0);
      add_req(REQ_PUT, 8'h2B, 8'h3D, 1'b0, 5, 5, 1'b0);
      add_req(REQ_PUT, 8'h2C, 8'hC3, 1'b0, 5, 5, 1'b0);
      add_req(REQ_READ, 0, 0, 1'b0, 78, 23, 1'b0);
      add_req(REQ_READ, 0, 0, 1'b0, 79, 23, 1'b0);
      add_req(REQ_READ, 0, 0, 1'b0, 0, 24, 1'b0);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            // text run, optionally placed near the bottom to force scrolls
            len = $urandom_range(5, 40);
            for (int i = 0; i < len; i++)
               add_req(REQ_PUT,
                       ($urandom_range(0, 9) == 0) ? NEWLINE_CODE : $urandom_range(0, 255),
                       $urandom_range(0, 255),
                       (i == 0) && ($urandom_range(0, 1) == 0),
                       $urandom_range(0, 127),
                       ($urandom_range(0, 1) == 0) ? $urandom_range(20, 31)
                                                   : $urandom_range(0, 31),
                       (i == 0) && ($urandom_range(0, 7) == 0));
         end else if (mode < 9) begin
            len = $urandom_range(3, 15);
            for (int i = 0; i < len; i++)
               add_req(REQ_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                       1'($urandom_range(0, 1)),
                       ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 127),
                       ($urandom_range(0, 1) == 0) ? $urandom_range(18, 31)
                                                   : $urandom_range(0, 31),
                       (i == 0) && ($urandom_range(0, 7) == 0));
         end else begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
               add_req(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                       $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 127), $urandom_range(0, 31), 1'b0);
         end
         n += len;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || issued_count != retired_count)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d puts and %0d reads with %0d scrolls and %0d drain pauses",
               put_count, read_count, scroll_count, drain_count);
      $display("%0d results checked, %0d mismatches", retired_count, mismatch_count);
      if (mismatch_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
